@@ rtl/nfci_pkg.sv @@
// Package for the NOR flash command interpreter: field widths, transaction structs,
// command codes, state enums and the autoselect ID table. Depends on nothing.
package nfci_pkg;

  localparam int unsigned ADDR_W      = 18;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned TICK_W      = 20;
  localparam int unsigned PROG_TICK_W = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned DEF_ADDR_BITS  = 18;
  localparam int unsigned DEF_BLOCK_BITS = 15;

  localparam logic [TICK_W-1:0] RST_PROG_TICKS  = 20'd10;
  localparam logic [TICK_W-1:0] RST_BLOCK_TICKS = 20'd5000;
  localparam logic [TICK_W-1:0] RST_CHIP_TICKS  = 20'd512000;

  localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0] CMD_RESET   = 8'hF0;
  localparam logic [7:0] CMD_AUTOSEL = 8'h90;
  localparam logic [7:0] CMD_PROGRAM = 8'hA0;
  localparam logic [7:0] CMD_ERASE   = 8'h80;
  localparam logic [7:0] CMD_BLOCK   = 8'h30;
  localparam logic [7:0] CMD_CHIP    = 8'h10;

  localparam logic [10:0] UNLOCK_ADDR1 = 11'h555;
  localparam logic [10:0] UNLOCK_ADDR2 = 11'h2AA;

  localparam logic [DATA_W-1:0] ERASED_WORD = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROG_TICKS  = 2'd0,
    CFG_BLOCK_TICKS = 2'd1,
    CFG_CHIP_TICKS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_READ, ST_UNLOCK1, ST_UNLOCK2, ST_AUTOSEL,
    ST_PROG, ST_ERASE, ST_EUNLOCK1, ST_EUNLOCK2
  } stage_e;

  typedef enum logic [1:0] {
    B_IDLE, B_READ, B_PROG, B_SWEEP
  } back_state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              busy_res;
  } out_t;

  // Classified transaction handed from the front to the back.
  typedef struct packed {
    func_e             op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              at_555;
    logic              at_2aa;
  } cmd_t;

  typedef struct packed {
    logic init_clear;
    logic busy;
  } back_status_t;

  function automatic logic [DATA_W-1:0] autoselect_word(input logic [7:0] ofs);
    logic [DATA_W-1:0] w;
    unique case (ofs)
      8'h00:   w = 16'h0001;
      8'h01:   w = 16'h227E;
      8'h0E:   w = 16'h2212;
      8'h0F:   w = 16'h2201;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/nor_flash_command_interpreter_top.sv @@
// Top level of the x16 NOR flash command interpreter.
// Depends on nfci_pkg, nfci_front, nfci_back (and nfci_ram below it).
//
//  Channel   Handshake           Payload
//  input     push / full         in_i  (func, address, write_data)
//  result    empty / pop         out_o (read_data, busy_res)
//  config    cfg_we_i            cfg_idx_i, cfg_data_i
//
// Most transactions are handled in the B_IDLE state of the back end; an array
// read also passes through B_READ because the array RAM has a registered read
// port, and a word program passes through B_PROG (read, then write of new AND
// old). An erase sweeps the block or the whole array one word per cycle before
// the next transaction is taken. After reset the same sweep runs over the whole
// array with full held high. The two-entry input queue and the result register
// let either side stall independently.
module nor_flash_command_interpreter_top #(
  parameter int unsigned ADDR_BITS  = nfci_pkg::DEF_ADDR_BITS,
  parameter int unsigned BLOCK_BITS = nfci_pkg::DEF_BLOCK_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  nfci_pkg::in_t                  in_i,
  output logic                           empty,
  input  logic                           pop,
  output nfci_pkg::out_t                 out_o,
  input  logic                           cfg_we_i,
  input  logic [nfci_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nfci_pkg::TICK_W-1:0]    cfg_data_i
);
  import nfci_pkg::*;

  cmd_t         cmd;
  logic         cmd_valid, cmd_take, q_full, q_push;
  back_status_t status;

  // Nothing is taken while the power-on clearing sweep runs.
  assign full   = q_full || status.init_clear;
  assign q_push = push && !status.init_clear;

  nfci_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (q_push),
    .full        (q_full),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  nfci_back #(.ADDR_BITS(ADDR_BITS), .BLOCK_BITS(BLOCK_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .status_o    (status)
  );

  // The clearing sweep must block the input side.
  a_init_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.init_clear |-> full) else $error("input open during clearing sweep");

  // No result can exist before any transaction was taken.
  a_init_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.init_clear |-> empty) else $error("result during clearing sweep");

  // The back end never takes a transaction the queue does not hold.
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd_valid) else $error("take from empty command queue");
endmodule

@@ rtl/nfci_ram.sv @@
// Generic single-port RAM with registered read data.
// Depends on nothing.
module nfci_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/nfci_front.sv @@
// Front end: two-entry input queue that classifies bus transactions.
// Depends on nfci_pkg.
module nfci_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  nfci_pkg::in_t  in_i,
  output logic           cmd_valid_o,
  input  logic           cmd_take_i,
  output nfci_pkg::cmd_t cmd_o
);
  import nfci_pkg::*;

  cmd_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.op      = func_e'(in_i.func);
    cls.address = in_i.address;
    cls.data    = in_i.write_data;
    cls.at_555  = in_i.address[10:0] == UNLOCK_ADDR1;
    cls.at_2aa  = in_i.address[10:0] == UNLOCK_ADDR2;
  end

  assign full        = count_q == 2'd2;
  assign cmd_valid_o = count_q != 2'd0;
  assign cmd_o       = buf_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

@@ rtl/nfci_back.sv @@
// Back end: command sequencer, busy timer, status bits, array RMW and erase sweeps,
// plus the one-entry result register. Depends on nfci_pkg and nfci_ram.
module nfci_back #(
  parameter int unsigned ADDR_BITS  = nfci_pkg::DEF_ADDR_BITS,
  parameter int unsigned BLOCK_BITS = nfci_pkg::DEF_BLOCK_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [nfci_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [nfci_pkg::TICK_W-1:0]           cfg_data_i,
  input  logic                                  cmd_valid_i,
  output logic                                  cmd_take_o,
  input  nfci_pkg::cmd_t                        cmd_i,
  output logic                                  empty,
  input  logic                                  pop,
  output nfci_pkg::out_t                        out_o,
  output nfci_pkg::back_status_t                status_o
);
  import nfci_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_BITS;
  localparam logic [ADDR_BITS-1:0] BLK_MASK = ADDR_BITS'((1 << BLOCK_BITS) - 1);

  back_state_e           state_q, state_d;
  stage_e                stage_q, stage_d;
  logic                  busy_q, busy_d;
  logic [TICK_W-1:0]     rem_q, rem_d;
  logic                  tog_q, tog_d, dq7_q, dq7_d;
  logic                  init_q, init_d;
  logic [ADDR_BITS-1:0]  cur_q, cur_d, end_q, end_d, paddr_q, paddr_d;
  logic [DATA_W-1:0]     pdata_q, pdata_d;
  logic                  ovalid_q, ovalid_d;
  out_t                  out_q, out_d;
  logic [PROG_TICK_W-1:0] prog_ticks_q;
  logic [TICK_W-1:0]     blk_ticks_q, chip_ticks_q;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_addr;
  logic [DATA_W-1:0]     ram_wdata, ram_rdata;

  logic                  slot_free, emit;
  logic [DATA_W-1:0]     rd;
  logic [ADDR_BITS-1:0]  a;
  logic [7:0]            d8;

  nfci_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign slot_free = !ovalid_q || pop;
  assign empty     = !ovalid_q;
  assign out_o     = out_q;
  assign status_o  = '{init_clear: init_q, busy: busy_q};

  always_comb begin
    state_d = state_q;  stage_d = stage_q;  busy_d = busy_q;  rem_d = rem_q;
    tog_d = tog_q;  dq7_d = dq7_q;  init_d = init_q;  cur_d = cur_q;  end_d = end_q;
    paddr_d = paddr_q;  pdata_d = pdata_q;
    ovalid_d = ovalid_q && !pop;
    out_d = out_q;
    ram_we = 1'b0;  ram_addr = cur_q;  ram_wdata = ERASED_WORD;
    cmd_take_o = 1'b0;  emit = 1'b0;  rd = '0;
    a  = ADDR_BITS'(cmd_i.address);
    d8 = cmd_i.data[7:0];

    unique case (state_q)
      B_SWEEP: begin
        ram_we = 1'b1;
        if (cur_q == end_q) begin
          state_d = B_IDLE;
          init_d  = 1'b0;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      B_READ: begin
        ovalid_d = 1'b1;
        out_d    = '{read_data: ram_rdata, busy_res: busy_q};
        state_d  = B_IDLE;
      end
      B_PROG: begin
        ram_we    = 1'b1;
        ram_addr  = paddr_q;
        ram_wdata = ram_rdata & pdata_q;
        state_d   = B_IDLE;
      end
      B_IDLE: begin
        ram_addr = a;
        if (cmd_valid_i && slot_free) begin
          cmd_take_o = 1'b1;
          emit       = 1'b1;
          unique case (cmd_i.op)
            FUNC_READ: begin
              if (busy_q) begin
                rd    = {8'h00, dq7_q, tog_q, 6'h00};
                tog_d = ~tog_q;
              end else if (stage_q == ST_AUTOSEL) begin
                rd = autoselect_word(cmd_i.address[7:0]);
              end else begin
                emit    = 1'b0;
                state_d = B_READ;
              end
            end
            FUNC_WRITE: begin
              if (!busy_q) begin
                unique case (stage_q)
                  ST_READ: begin
                    if (cmd_i.at_555 && d8 == CMD_UNLOCK1) stage_d = ST_UNLOCK1;
                  end
                  ST_UNLOCK1: begin
                    stage_d = (cmd_i.at_2aa && d8 == CMD_UNLOCK2) ? ST_UNLOCK2 : ST_READ;
                  end
                  ST_UNLOCK2: begin
                    stage_d = ST_READ;
                    if (cmd_i.at_555) begin
                      priority if (d8 == CMD_AUTOSEL) stage_d = ST_AUTOSEL;
                      else if (d8 == CMD_PROGRAM)     stage_d = ST_PROG;
                      else if (d8 == CMD_ERASE)       stage_d = ST_ERASE;
                      else                            stage_d = ST_READ;
                    end
                  end
                  ST_AUTOSEL: begin
                    if (d8 == CMD_RESET) stage_d = ST_READ;
                  end
                  ST_PROG: begin
                    paddr_d = a;
                    pdata_d = cmd_i.data;
                    dq7_d   = ~cmd_i.data[7];
                    rem_d   = TICK_W'(prog_ticks_q);
                    busy_d  = prog_ticks_q != '0;
                    stage_d = ST_READ;
                    state_d = B_PROG;
                  end
                  ST_ERASE: begin
                    stage_d = (cmd_i.at_555 && d8 == CMD_UNLOCK1) ? ST_EUNLOCK1 : ST_READ;
                  end
                  ST_EUNLOCK1: begin
                    stage_d = (cmd_i.at_2aa && d8 == CMD_UNLOCK2) ? ST_EUNLOCK2 : ST_READ;
                  end
                  ST_EUNLOCK2: begin
                    stage_d = ST_READ;
                    priority if (cmd_i.at_555 && d8 == CMD_CHIP) begin
                      cur_d   = '0;
                      end_d   = '1;
                      dq7_d   = 1'b0;
                      rem_d   = chip_ticks_q;
                      busy_d  = chip_ticks_q != '0;
                      state_d = B_SWEEP;
                    end else if (d8 == CMD_BLOCK) begin
                      cur_d   = a & ~BLK_MASK;
                      end_d   = a | BLK_MASK;
                      dq7_d   = 1'b0;
                      rem_d   = blk_ticks_q;
                      busy_d  = blk_ticks_q != '0;
                      state_d = B_SWEEP;
                    end else begin
                      stage_d = ST_READ;
                    end
                  end
                  default: stage_d = ST_READ;
                endcase
              end
            end
            FUNC_TICK: begin
              if (busy_q) begin
                rem_d = rem_q - 1'b1;
                if (rem_q == TICK_W'(1)) busy_d = 1'b0;
              end
            end
            default: ;
          endcase
          if (emit) begin
            ovalid_d = 1'b1;
            out_d    = '{read_data: rd, busy_res: busy_d};
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_SWEEP;  stage_q <= ST_READ;  busy_q <= 1'b0;  rem_q <= '0;
      tog_q <= 1'b0;  dq7_q <= 1'b0;  init_q <= 1'b1;
      cur_q <= '0;  end_q <= '1;  ovalid_q <= 1'b0;
      prog_ticks_q <= PROG_TICK_W'(RST_PROG_TICKS);
      blk_ticks_q  <= RST_BLOCK_TICKS;
      chip_ticks_q <= RST_CHIP_TICKS;
    end else begin
      state_q <= state_d;  stage_q <= stage_d;  busy_q <= busy_d;  rem_q <= rem_d;
      tog_q <= tog_d;  dq7_q <= dq7_d;  init_q <= init_d;
      cur_q <= cur_d;  end_q <= end_d;  ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PROG_TICKS:  prog_ticks_q <= cfg_data_i[PROG_TICK_W-1:0];
          CFG_BLOCK_TICKS: blk_ticks_q  <= cfg_data_i;
          CFG_CHIP_TICKS:  chip_ticks_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    pdata_q <= pdata_d;
    out_q   <= out_d;
  end
endmodule
